>>> rtl/core/ttad_pkg.sv
`timescale 1ns / 1ps

package ttad_pkg;

    typedef logic [6:0] t_code;

    // Serial attributes carried from cell to cell within a row
    typedef struct packed {
        logic [2:0] fg;
        logic [2:0] bg;
        logic       mosaic;
        logic       sep;
        logic       hold;
        t_code      held;
        logic       big;
        logic       row_dbl;
    } t_attr;

    // Outcome of closing a row
    typedef struct packed {
        logic       page_over;
        logic [4:0] row;
        logic       skip;
    } t_row_end;

    localparam t_code CODE_MASK  = 7'h7F;
    localparam t_code C_ROW_END  = 7'h0D;
    localparam t_code C_ESC      = 7'h1B;
    localparam t_code C_SPACE    = 7'h20;
    localparam t_code ESC_BASE   = 7'h40;
    localparam t_code BARE_BASE  = 7'h00;

    // Control offsets from the base of the active code set
    localparam t_code OFS_ALPHA_LO = 7'h00;
    localparam t_code OFS_ALPHA_HI = 7'h07;
    localparam t_code OFS_FLASH    = 7'h08;
    localparam t_code OFS_STEADY   = 7'h09;
    localparam t_code OFS_NORM_HT  = 7'h0C;
    localparam t_code OFS_DBL_HT   = 7'h0D;
    localparam t_code OFS_MOS_LO   = 7'h10;
    localparam t_code OFS_MOS_HI   = 7'h17;
    localparam t_code OFS_CONCEAL  = 7'h18;
    localparam t_code OFS_CONTIG   = 7'h19;
    localparam t_code OFS_SEPAR    = 7'h1A;
    localparam t_code OFS_BLACK_BG = 7'h1C;
    localparam t_code OFS_NEW_BG   = 7'h1D;
    localparam t_code OFS_HOLD     = 7'h1E;
    localparam t_code OFS_RELEASE  = 7'h1F;

    localparam logic [2:0] FG_RESET = 3'd7;
    localparam logic [2:0] BG_RESET = 3'd0;
    localparam logic [5:0] MAX_ROWS = 6'd32;

    localparam t_attr ATTR_RESET = '{
        fg: FG_RESET, bg: BG_RESET, mosaic: 1'b0, sep: 1'b0, hold: 1'b0,
        held: C_SPACE, big: 1'b0, row_dbl: 1'b0
    };

endpackage

>>> rtl/core/ttad_chain.sv
`timescale 1ns / 1ps

// Attribute decision chain: each check sees the code left by the one before.
module ttad_chain
    import ttad_pkg::*;
(
    input  t_code i_code,
    input  logic  i_esc,
    input  t_attr i_attr,
    output t_code o_code,
    output t_attr o_attr
);

    always_comb begin
        t_code c;
        t_code b;
        t_attr a;
        a = i_attr;
        c = i_code;
        b = i_esc ? ESC_BASE : BARE_BASE;

        if (c >= b + OFS_ALPHA_LO && c <= b + OFS_ALPHA_HI) begin
            a.fg     = c[2:0];
            a.mosaic = 1'b0;
            a.held   = C_SPACE;
            c        = a.held;
        end
        if (c >= b + OFS_MOS_LO && c <= b + OFS_MOS_HI) begin
            a.fg     = c[2:0];
            a.mosaic = 1'b1;
            c        = a.held;
        end
        if (c == b + OFS_CONTIG) begin
            a.sep = 1'b0;
            c     = a.held;
        end
        if (c == b + OFS_SEPAR) begin
            a.sep = 1'b1;
            c     = a.held;
        end
        if (c == b + OFS_BLACK_BG) begin
            a.bg = BG_RESET;
            c    = a.held;
        end
        if (c == b + OFS_NEW_BG) begin
            a.bg = a.fg;
            c    = a.held;
        end
        if (c == b + OFS_NORM_HT) begin
            a.big = 1'b0;
            c     = a.held;
        end
        if (c == b + OFS_DBL_HT) begin
            a.big     = 1'b1;
            a.row_dbl = 1'b1;
            c         = a.held;
        end
        if (c == b + OFS_FLASH || c == b + OFS_STEADY || c == b + OFS_CONCEAL) begin
            c = a.held;
        end
        if (c == b + OFS_HOLD) begin
            a.hold = 1'b1;
            a.held = C_SPACE;
            c      = a.held;
        end
        if (c == b + OFS_RELEASE) begin
            a.hold = 1'b0;
            a.held = C_SPACE;
            c      = a.held;
        end

        o_code = c;
        o_attr = a;
    end

endmodule

>>> rtl/core/teletext_attribute_decoder_top.sv
`timescale 1ns / 1ps

// Serial teletext attribute decoder. Takes one page byte per transfer (low 7 bits
// used, tuser flags the first byte of a page) and emits one cell per drawn byte.
// Throughput is one byte per clock while the output is not stalled: a byte sits in
// the input register while the attribute chain and row/column update run, and its
// cell lands in the output register. Row end, ESC and skipped bytes produce no
// output transfer. The row count register may only be written while no bytes are
// in flight.
module teletext_attribute_decoder_top
    import ttad_pkg::*;
#(
    parameter int ROW_CELLS = 40
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [5:0]  i_cfg_wdata,     // rows_per_page
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] code_byte
    input  logic        s_axis_tuser,    // [0] new_page
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [4:0] cell_row, [10:5] cell_col,
                                         // [18:11] glyph_code, [21:19] fore_colour,
                                         // [24:22] back_colour, [25] tall_font,
                                         // [26] fill_below, [31:27] zero
);

    localparam logic [5:0] CELLS = 6'(ROW_CELLS);

    logic [5:0] r_rows;
    logic       r_in_valid;
    t_code      r_in_code;
    logic       r_in_new;

    logic       r_esc_pend, r_esc_only, r_page_over;
    t_attr      r_attr;
    logic [4:0] r_row;
    logic [5:0] r_col;
    logic [5:0] r_skip;

    logic        r_out_valid;
    logic [26:0] r_out_data;

    logic       n_esc_pend, n_esc_only, n_page_over;
    t_attr      n_attr;
    logic [4:0] n_row;
    logic [5:0] n_col;
    logic [5:0] n_skip;
    logic       n_draw;
    logic [26:0] n_out_data;

    logic       w_consume;
    logic [5:0] w_eff;
    t_attr      w_s_attr;
    logic       w_s_esc_pend, w_s_esc_only, w_s_page_over;
    logic [4:0] w_s_row;
    logic [5:0] w_s_col;
    logic [5:0] w_s_skip;
    t_code      w_ch_code;
    t_attr      w_ch_attr;

    assign w_consume     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_consume;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_data};
    assign w_eff         = (r_rows > MAX_ROWS) ? MAX_ROWS : r_rows;

    // A new page clears everything before the byte is looked at
    assign w_s_attr      = r_in_new ? ATTR_RESET : r_attr;
    assign w_s_esc_pend  = r_in_new ? 1'b0 : r_esc_pend;
    assign w_s_esc_only  = r_in_new ? 1'b0 : r_esc_only;
    assign w_s_page_over = r_in_new ? 1'b0 : r_page_over;
    assign w_s_row       = r_in_new ? 5'd0 : r_row;
    assign w_s_col       = r_in_new ? 6'd0 : r_col;
    assign w_s_skip      = r_in_new ? 6'd0 : r_skip;

    ttad_chain u_chain (
        .i_code (r_in_code),
        .i_esc  (w_s_esc_pend),
        .i_attr (w_s_attr),
        .o_code (w_ch_code),
        .o_attr (w_ch_attr)
    );

    function automatic t_row_end row_end(input logic [4:0] row, input logic dbl,
                                         input logic [5:0] eff);
        t_row_end   r;
        logic [5:0] nxt1;
        logic [5:0] nxt2;
        nxt1        = {1'b0, row} + 6'd1;
        nxt2        = {1'b0, row} + 6'd2;
        r.page_over = 1'b0;
        r.skip      = 1'b0;
        r.row       = row;
        if (nxt1 >= eff) begin
            r.page_over = 1'b1;
        end else if (dbl) begin
            if (nxt2 >= eff) begin
                r.page_over = 1'b1;
            end else begin
                r.skip = 1'b1;
                r.row  = nxt2[4:0];
            end
        end else begin
            r.row = nxt1[4:0];
        end
        return r;
    endfunction

    always_comb begin
        t_code      c;
        logic [7:0] add;
        logic [6:0] col_inc;
        t_row_end   re;
        logic       apply;

        n_esc_pend  = w_s_esc_pend;
        n_esc_only  = w_s_esc_only;
        n_page_over = w_s_page_over;
        n_attr      = w_s_attr;
        n_row       = w_s_row;
        n_col       = w_s_col;
        n_skip      = w_s_skip;
        n_draw      = 1'b0;
        c           = r_in_code;
        add         = 8'd0;
        apply       = 1'b0;
        col_inc     = {1'b0, w_s_col} + 7'd1;
        re          = row_end(w_s_row, w_s_attr.row_dbl, w_eff);
        n_out_data  = '0;

        if (w_s_page_over || {1'b0, w_s_row} >= w_eff) begin
            // page finished: byte ignored
        end else if (w_s_skip != 6'd0) begin
            n_skip = w_s_skip - 6'd1;
        end else if (w_s_esc_pend) begin
            n_esc_pend = 1'b0;
            n_esc_only = 1'b1;
            apply      = 1'b1;
            n_draw     = 1'b1;
        end else if (r_in_code == C_ROW_END) begin
            n_attr      = ATTR_RESET;
            n_page_over = re.page_over;
            n_row       = re.row;
            n_skip      = re.skip ? CELLS : w_s_skip;
            n_col       = 6'd0;
        end else if (r_in_code == C_ESC) begin
            n_esc_pend = 1'b1;
        end else begin
            apply  = !w_s_esc_only;
            n_draw = 1'b1;
        end

        if (n_draw) begin
            if (apply) begin
                c      = w_ch_code;
                n_attr = w_ch_attr;
            end
            if (n_attr.mosaic) begin
                if (c >= 7'h20 && c <= 7'h3F) begin
                    add = n_attr.sep ? 8'd160 : 8'd96;
                end else if (c >= 7'h60) begin
                    add = n_attr.sep ? 8'd128 : 8'd64;
                end
                if (n_attr.hold) begin
                    n_attr.held = c;
                end
            end
            n_out_data = {
                (!n_attr.big && ({1'b0, w_s_row} + 6'd1 < w_eff)),
                n_attr.big,
                n_attr.bg,
                n_attr.fg,
                8'({1'b0, c} + add),
                w_s_col,
                w_s_row
            };
            if (col_inc >= {1'b0, CELLS}) begin
                re          = row_end(w_s_row, n_attr.row_dbl, w_eff);
                n_attr      = ATTR_RESET;
                n_page_over = re.page_over;
                n_row       = re.row;
                n_skip      = re.skip ? CELLS : w_s_skip;
                n_col       = 6'd0;
            end else begin
                n_col = col_inc[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 6'd24;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_esc_pend  <= 1'b0;
            r_esc_only  <= 1'b0;
            r_page_over <= 1'b0;
            r_attr      <= ATTR_RESET;
            r_row       <= 5'd0;
            r_col       <= 6'd0;
            r_skip      <= 6'd0;
        end else begin
            if (i_cfg_wen) begin
                r_rows <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_consume) begin
                r_esc_pend  <= n_esc_pend;
                r_esc_only  <= n_esc_only;
                r_page_over <= n_page_over;
                r_attr      <= n_attr;
                r_row       <= n_row;
                r_col       <= n_col;
                r_skip      <= n_skip;
            end
            if (w_consume && n_draw) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_code <= s_axis_tdata[6:0] & CODE_MASK;
            r_in_new  <= s_axis_tuser;
        end
        if (w_consume && n_draw) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
